// File: rtl/ssr_pkg.sv
package ssr_pkg;

    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 32;
    localparam int LEN_W      = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LEN  = 3'd5;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // per-job control carried from front to back
    typedef struct packed {
        logic             bare;
        logic             eos;
        logic [CNT_W-1:0] count;
    } t_job_ctl;

endpackage

// File: rtl/ssr_front.sv
module ssr_front #(
    parameter int MAX_LEN = 16,
    parameter int CW      = 5,
    parameter int IW      = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_fire,
    input  logic [ssr_pkg::BYTE_W-1:0]            i_byte,
    input  logic                                  i_last,
    output logic                                  o_job_valid,
    output logic [MAX_LEN*ssr_pkg::BYTE_W-1:0]    o_job_bytes,
    output logic [CW-1:0]                         o_job_n,
    output ssr_pkg::t_job_ctl                     o_job_ctl
);

    localparam int BW = ssr_pkg::BYTE_W;
    localparam logic [ssr_pkg::LEN_W-1:0] MAX_LEN5 = ssr_pkg::LEN_W'(MAX_LEN);
    localparam logic [CW-1:0] MAX_LEN_C = CW'(MAX_LEN);

    logic [ssr_pkg::CFG_DATA_W-1:0] r_pat_lo, r_pat_hi, r_rep_lo, r_rep_hi;
    logic [ssr_pkg::LEN_W-1:0]      r_plen_raw, r_rlen_raw;
    logic [BW-1:0]                  r_win [MAX_LEN];
    logic [BW-1:0]                  n_win [MAX_LEN];
    logic [CW-1:0]                  r_fill, n_fill;
    logic [ssr_pkg::CNT_W-1:0]      r_total, n_total;

    logic [2*ssr_pkg::CFG_DATA_W-1:0] pat_all, rep_all;
    logic [ssr_pkg::LEN_W-1:0]        plen5, rlen5;
    logic [CW-1:0]                    plen, rlen, fill_a, n_out, n_job;
    logic [BW-1:0]                    w_app [MAX_LEN];
    logic                             same, over, eq, match;
    logic [ssr_pkg::CNT_W-1:0]        tot_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo   <= '0;
            r_pat_hi   <= '0;
            r_rep_lo   <= '0;
            r_rep_hi   <= '0;
            r_plen_raw <= ssr_pkg::LEN_W'(1);
            r_rlen_raw <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ssr_pkg::CFG_PATTERN_LOW:      r_pat_lo   <= i_cfg_data;
                ssr_pkg::CFG_PATTERN_HIGH:     r_pat_hi   <= i_cfg_data;
                ssr_pkg::CFG_REPLACEMENT_LOW:  r_rep_lo   <= i_cfg_data;
                ssr_pkg::CFG_REPLACEMENT_HIGH: r_rep_hi   <= i_cfg_data;
                ssr_pkg::CFG_PATTERN_LEN:      r_plen_raw <= i_cfg_data[ssr_pkg::LEN_W-1:0];
                ssr_pkg::CFG_REPLACEMENT_LEN:  r_rlen_raw <= i_cfg_data[ssr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pat_all = {r_pat_hi, r_pat_lo};
        rep_all = {r_rep_hi, r_rep_lo};
        if (r_plen_raw == '0) begin
            plen5 = ssr_pkg::LEN_W'(1);
        end else if (r_plen_raw > MAX_LEN5) begin
            plen5 = MAX_LEN5;
        end else begin
            plen5 = r_plen_raw;
        end
        rlen5 = (r_rlen_raw > MAX_LEN5) ? MAX_LEN5 : r_rlen_raw;
        plen  = plen5[CW-1:0];
        rlen  = rlen5[CW-1:0];
    end

    // append the new byte unless the window is already full
    always_comb begin
        w_app  = r_win;
        fill_a = r_fill;
        if (r_fill < MAX_LEN_C) begin
            w_app[r_fill[IW-1:0]] = i_byte;
            fill_a = r_fill + CW'(1);
        end
    end

    always_comb begin
        same = 1'b1;
        for (int i = 0; i < MAX_LEN; i++) begin
            if (CW'(i) < plen && w_app[i] != pat_all[BW*i +: BW]) begin
                same = 1'b0;
            end
        end
        over  = fill_a > plen;
        eq    = fill_a == plen;
        match = eq && same;
    end

    always_comb begin
        n_win   = w_app;
        n_fill  = fill_a;
        n_out   = '0;
        tot_new = r_total;
        if (over) begin
            n_out  = CW'(2);
            n_fill = fill_a - CW'(2);
            for (int i = 0; i < MAX_LEN; i++) begin
                if (i + 2 < MAX_LEN) begin
                    n_win[i] = w_app[i + 2];
                end
            end
        end else if (match) begin
            n_out  = rlen;
            n_fill = '0;
            if (r_total != ssr_pkg::COUNT_MAX) begin
                tot_new = r_total + ssr_pkg::CNT_W'(1);
            end
        end else if (eq) begin
            n_out  = CW'(1);
            n_fill = fill_a - CW'(1);
            for (int i = 0; i < MAX_LEN; i++) begin
                if (i + 1 < MAX_LEN) begin
                    n_win[i] = w_app[i + 1];
                end
            end
        end
        n_total = tot_new;
        if (i_last) begin
            n_fill  = '0;
            n_total = '0;
        end
    end

    // on the last byte everything left in the window follows what was emitted,
    // which is the appended window in order unless a match took place
    always_comb begin
        n_job = n_out;
        if (i_last) begin
            n_job = match ? rlen : fill_a;
        end
        o_job_ctl.bare  = (n_job == '0);
        o_job_ctl.eos   = i_last;
        o_job_ctl.count = tot_new;
        o_job_n         = (n_job == '0) ? CW'(1) : n_job;
        o_job_valid     = i_fire && (i_last || n_out != '0);
        for (int i = 0; i < MAX_LEN; i++) begin
            if (n_job == '0) begin
                o_job_bytes[BW*i +: BW] = '0;
            end else if (match) begin
                o_job_bytes[BW*i +: BW] = rep_all[BW*i +: BW];
            end else begin
                o_job_bytes[BW*i +: BW] = w_app[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_total <= '0;
        end else if (i_fire) begin
            r_fill  <= n_fill;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_win <= n_win;
        end
    end

endmodule

// File: rtl/ssr_fifo.sv
module ssr_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(ssr_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(ssr_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [ssr_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [NW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == NW'(ssr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/ssr_back.sv
module ssr_back #(
    parameter int MAX_LEN = 16,
    parameter int CW      = 5,
    parameter int IW      = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_head_valid,
    input  logic [MAX_LEN*ssr_pkg::BYTE_W-1:0] i_head_bytes,
    input  logic [CW-1:0]                      i_head_n,
    input  ssr_pkg::t_job_ctl                  i_head_ctl,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [ssr_pkg::BYTE_W-1:0]         o_byte,
    output logic                               o_has_byte,
    output logic                               o_run_last,
    output logic                               o_eos,
    output logic [ssr_pkg::CNT_W-1:0]          o_count
);

    localparam int BW = ssr_pkg::BYTE_W;

    logic [IW-1:0]            r_idx;
    logic                     r_valid;
    logic [BW-1:0]            r_byte;
    logic                     r_has, r_last, r_eos;
    logic [ssr_pkg::CNT_W-1:0] r_count;
    logic                     load, final_byte;

    assign load       = i_head_valid && (!r_valid || i_ready);
    assign final_byte = (CW'(r_idx) + CW'(1)) == i_head_n;
    assign o_pop      = load && final_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= final_byte ? '0 : r_idx + IW'(1);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte  <= i_head_bytes[BW*r_idx +: BW];
            r_has   <= !i_head_ctl.bare;
            r_last  <= final_byte;
            r_eos   <= final_byte && i_head_ctl.eos;
            r_count <= i_head_ctl.count;
        end
    end

    assign o_valid    = r_valid;
    assign o_byte     = r_byte;
    assign o_has_byte = r_has;
    assign o_run_last = r_last;
    assign o_eos      = r_eos;
    assign o_count    = r_count;

endmodule

// File: rtl/stream_search_and_replace.sv
// path: the results of an input transfer are registered in the job queue and then in the
// output stage before they appear on m_axis
// throughput: one byte per cycle in and out while m_axis_tready is high; an item with n
// results makes n output transfers, and input stalls once the two-entry job queue is full
// reset: synchronous active low; config returns to defaults (pattern length 1,
// empty replacement), window empty, count zero, job queue and output stage empty
module stream_search_and_replace #(
    parameter int MAX_LEN = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,   // [7:0] data_byte
    input  logic                                 s_axis_tlast,   // stream_last
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [39:0]                          m_axis_tdata,   // [7:0] out_byte, [39:8] replaced_count
    output logic [1:0]                           m_axis_tuser,   // [0] has_byte, [1] end_of_stream
    output logic                                 m_axis_tlast    // run_last
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int BYTES_W = MAX_LEN * ssr_pkg::BYTE_W;
    localparam int CTL_W = $bits(ssr_pkg::t_job_ctl);
    localparam int JOB_W = BYTES_W + CW + CTL_W;

    logic                  fire, job_valid, q_full, q_valid, q_pop;
    logic [BYTES_W-1:0]    job_bytes, head_bytes;
    logic [CW-1:0]         job_n, head_n;
    ssr_pkg::t_job_ctl     job_ctl, head_ctl;
    logic [JOB_W-1:0]      q_in, q_out;
    logic [ssr_pkg::BYTE_W-1:0] out_byte;
    logic [ssr_pkg::CNT_W-1:0]  out_count;
    logic                  out_has, out_eos;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !q_full;
    assign fire          = s_axis_tvalid && s_axis_tready;

    ssr_front #(.MAX_LEN(MAX_LEN), .CW(CW), .IW(IW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (fire),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_job_valid (job_valid),
        .o_job_bytes (job_bytes),
        .o_job_n     (job_n),
        .o_job_ctl   (job_ctl)
    );

    assign q_in = {job_ctl, job_n, job_bytes};
    assign {head_ctl, head_n, head_bytes} = q_out;

    ssr_fifo #(.WIDTH(JOB_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    ssr_back #(.MAX_LEN(MAX_LEN), .CW(CW), .IW(IW)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head_bytes (head_bytes),
        .i_head_n     (head_n),
        .i_head_ctl   (head_ctl),
        .o_pop        (q_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (out_byte),
        .o_has_byte   (out_has),
        .o_run_last   (m_axis_tlast),
        .o_eos        (out_eos),
        .o_count      (out_count)
    );

    assign m_axis_tdata = {out_count, out_byte};
    assign m_axis_tuser = {out_eos, out_has};

endmodule

// File: tb/testbench.sv
module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WIN_DEPTH      = 16;
    localparam int DIRECTED_ITEMS = 22;
    localparam int RANDOM_ITEMS   = 440;

    // indexes past the register file, writes there must be ignored
    localparam logic [ssr_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [ssr_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hold;
    } t_stream_item;

    typedef struct packed {
        logic [7:0]                out_byte;
        logic                      has_byte;
        logic                      run_last;
        logic                      eos;
        logic [ssr_pkg::CNT_W-1:0] count;
    } t_out_rec;

    typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_THIRD, STALL_HEAVY} t_stall_mode;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [ssr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [ssr_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata;   // [7:0] data_byte
    logic                           s_axis_tlast;   // stream_last
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [39:0]                    m_axis_tdata;   // [7:0] out_byte, [39:8] replaced_count
    logic [1:0]                     m_axis_tuser;   // [0] has_byte, [1] end_of_stream
    logic                           m_axis_tlast;   // run_last

    stream_search_and_replace DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // predictor state
    logic [63:0]               cur_pat_lo, cur_pat_hi, cur_rep_lo, cur_rep_hi;
    logic [ssr_pkg::LEN_W-1:0] cur_pat_len, cur_rep_len;
    logic [7:0]                win_buf [WIN_DEPTH];
    int                        win_fill;
    logic [ssr_pkg::CNT_W-1:0] replace_total;
    t_out_rec                  run_recs[$];
    t_out_rec                  due_q[$];

    // stimulus side
    t_stream_item     stream_q[$];
    logic [7:0]       pat_bytes [WIN_DEPTH];
    logic [7:0]       rep_bytes [WIN_DEPTH];
    int               pat_used = 1;
    int               items_pushed = 0;
    int               items_taken = 0;
    int               mismatches = 0;
    int               quiet_cycles = 0;
    bit               in_fired = 1'b0;
    int               gap_left = 0;
    int               burst_left = 0;
    int               stall_left = 0;
    t_stall_mode      stall_mode = STALL_NONE;

    function automatic logic [7:0] pick_byte(logic [63:0] lo, logic [63:0] hi, int idx);
        return (idx < 8) ? lo[8*idx +: 8] : hi[8*(idx-8) +: 8];
    endfunction

    function automatic logic [7:0] pop_oldest();
        logic [7:0] b;
        b = win_buf[0];
        for (int i = 1; i < WIN_DEPTH; i++)
            win_buf[i-1] = win_buf[i];
        if (win_fill > 0)
            win_fill--;
        return b;
    endfunction

    function automatic void add_out(logic [7:0] b, logic has);
        t_out_rec r;
        r = '0;
        r.out_byte = b;
        r.has_byte = has;
        run_recs.push_back(r);
    endfunction

    function automatic void replace_step(logic [7:0] din, logic din_last);
        int plen;
        int rlen;
        bit same;
        run_recs.delete();
        plen = (cur_pat_len == 0) ? 1 : ((cur_pat_len > WIN_DEPTH) ? WIN_DEPTH : int'(cur_pat_len));
        rlen = (cur_rep_len > WIN_DEPTH) ? WIN_DEPTH : int'(cur_rep_len);
        if (win_fill < WIN_DEPTH) begin
            win_buf[win_fill] = din;
            win_fill++;
        end
        // window ahead of a shortened pattern: drain two per item with no compare
        if (win_fill > plen) begin
            add_out(pop_oldest(), 1'b1);
            add_out(pop_oldest(), 1'b1);
        end else if (win_fill == plen) begin
            same = 1'b1;
            for (int i = 0; i < plen; i++)
                if (win_buf[i] != pick_byte(cur_pat_lo, cur_pat_hi, i))
                    same = 1'b0;
            if (same) begin
                for (int i = 0; i < rlen; i++)
                    add_out(pick_byte(cur_rep_lo, cur_rep_hi, i), 1'b1);
                win_fill = 0;
                if (replace_total != ssr_pkg::COUNT_MAX)
                    replace_total++;
            end else begin
                add_out(pop_oldest(), 1'b1);
            end
        end
        if (din_last) begin
            while (win_fill > 0)
                add_out(pop_oldest(), 1'b1);
            if (run_recs.size() == 0)
                add_out(8'h00, 1'b0);
        end
        foreach (run_recs[i]) begin
            run_recs[i].count    = replace_total;
            run_recs[i].run_last = (i == run_recs.size() - 1);
            run_recs[i].eos      = din_last && (i == run_recs.size() - 1);
            due_q.push_back(run_recs[i]);
        end
        if (din_last) begin
            win_fill      = 0;
            replace_total = '0;
        end
    endfunction

    function automatic void check_field(string label, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0h, got %0h", label, want_v, got_v);
            mismatches++;
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // monitor: config, input and output transfers, predictor update
    always @(posedge i_clk) begin
        t_out_rec want;
        if (!i_rst_n) begin
            cur_pat_lo    = '0;
            cur_pat_hi    = '0;
            cur_rep_lo    = '0;
            cur_rep_hi    = '0;
            cur_pat_len   = 5'd1;
            cur_rep_len   = '0;
            win_fill      = 0;
            replace_total = '0;
            in_fired      = 1'b0;
            quiet_cycles++;
        end else begin
            in_fired = s_axis_tvalid && s_axis_tready;
            if ((i_cfg_valid && o_cfg_ready) || in_fired || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ssr_pkg::CFG_PATTERN_LOW:      cur_pat_lo  = i_cfg_data;
                    ssr_pkg::CFG_PATTERN_HIGH:     cur_pat_hi  = i_cfg_data;
                    ssr_pkg::CFG_REPLACEMENT_LOW:  cur_rep_lo  = i_cfg_data;
                    ssr_pkg::CFG_REPLACEMENT_HIGH: cur_rep_hi  = i_cfg_data;
                    ssr_pkg::CFG_PATTERN_LEN:
                        cur_pat_len = i_cfg_data[ssr_pkg::LEN_W-1:0];
                    ssr_pkg::CFG_REPLACEMENT_LEN:
                        cur_rep_len = i_cfg_data[ssr_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_q.size() == 0) begin
                    $error("unexpected output transfer: byte %0h", m_axis_tdata[7:0]);
                    mismatches++;
                end else begin
                    want = due_q.pop_front();
                    check_field("out_byte", want.out_byte, m_axis_tdata[7:0]);
                    check_field("has_byte", want.has_byte, m_axis_tuser[0]);
                    check_field("run_last", want.run_last, m_axis_tlast);
                    check_field("end_of_stream", want.eos, m_axis_tuser[1]);
                    check_field("replaced_count", want.count, m_axis_tdata[39:8]);
                end
            end
            if (in_fired) begin
                items_taken++;
                replace_step(s_axis_tdata, s_axis_tlast);
            end
        end
    end

    // source: bursts with random gaps, some items wait for the output to drain
    always @(negedge i_clk) begin
        t_stream_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fired) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (stream_q.size() != 0 && !(stream_q[0].hold && due_q.size() != 0)) begin
                nxt = stream_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.data;
                s_axis_tlast  <= nxt.last;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink: backpressure pattern switches at random among four stall modes
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 80);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  m_axis_tready <= 1'b1;
            STALL_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
            STALL_THIRD: m_axis_tready <= (stall_left % 3 == 0);
            default:     m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(negedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_item(logic [7:0] b, logic last, logic hold);
        t_stream_item it;
        it.data = b;
        it.last = last;
        it.hold = hold;
        stream_q.push_back(it);
        items_pushed++;
    endtask

    task automatic settle();
        while (items_pushed != items_taken || due_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [ssr_pkg::CFG_IDX_W-1:0] idx,
                             logic [ssr_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    task automatic release_cfg();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_setup(logic [ssr_pkg::LEN_W-1:0] plen_raw,
                               logic [ssr_pkg::LEN_W-1:0] rlen_raw);
        logic [63:0] pl, ph, rl, rh, junk;
        for (int i = 0; i < 8; i++) begin
            pl[8*i +: 8] = pat_bytes[i];
            ph[8*i +: 8] = pat_bytes[i+8];
            rl[8*i +: 8] = rep_bytes[i];
            rh[8*i +: 8] = rep_bytes[i+8];
        end
        write_reg(ssr_pkg::CFG_PATTERN_LOW, pl);
        write_reg(ssr_pkg::CFG_PATTERN_HIGH, ph);
        write_reg(ssr_pkg::CFG_REPLACEMENT_LOW, rl);
        write_reg(ssr_pkg::CFG_REPLACEMENT_HIGH, rh);
        // upper data bits are don't-care for the length registers
        junk = {$urandom, $urandom};
        write_reg(ssr_pkg::CFG_PATTERN_LEN, {junk[63:ssr_pkg::LEN_W], plen_raw});
        junk = {$urandom, $urandom};
        write_reg(ssr_pkg::CFG_REPLACEMENT_LEN, {junk[63:ssr_pkg::LEN_W], rlen_raw});
        if ($urandom_range(0, 3) == 0)
            write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_6 : CFG_SPARE_7,
                      {$urandom, $urandom});
        release_cfg();
        pat_used = (plen_raw == 0) ? 1 : ((plen_raw > WIN_DEPTH) ? WIN_DEPTH : int'(plen_raw));
    endtask

    // whole or partial pattern copies, with pattern-alphabet and random filler
    task automatic send_stream(int len, bit closed);
        int k;
        int part;
        k = 0;
        while (k < len) begin
            case ($urandom_range(0, 9))
                0, 1, 2: part = pat_used;
                3:       part = $urandom_range(1, pat_used);
                default: part = 0;
            endcase
            if (part > 0) begin
                for (int j = 0; j < part; j++)
                    push_item(pat_bytes[j], 1'b0, ($urandom_range(0, 79) == 0));
                k += part;
            end else begin
                push_item(($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                      : pat_bytes[$urandom_range(0, pat_used-1)],
                          1'b0, ($urandom_range(0, 79) == 0));
                k++;
            end
        end
        if (closed)
            push_item(pat_bytes[$urandom_range(0, pat_used-1)], 1'b1, 1'b0);
    endtask

    initial begin
        logic [ssr_pkg::LEN_W-1:0] plen_raw, rlen_raw;
        logic [7:0]                base;
        bit                        full_rand;
        int                        n_streams;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b1;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            pat_bytes[i] = 8'h41 + 8'(i);
            rep_bytes[i] = 8'(i * 8'h11) ^ 8'h5a;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: single zero byte gets deleted, lone last byte gives a bare marker
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        settle();

        // three-byte pattern, full 16-byte replacement, a match and then a shifted match
        write_setup(5'd3, 5'd16);
        push_item(8'h41, 1'b0, 1'b0);
        push_item(8'h42, 1'b0, 1'b0);
        push_item(8'h43, 1'b0, 1'b0);
        push_item(8'h41, 1'b0, 1'b1);
        push_item(8'h41, 1'b0, 1'b0);
        push_item(8'h42, 1'b0, 1'b0);
        push_item(8'h43, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'hff, 1'b1, 1'b0);
        settle();

        // zero pattern length acts as one, oversized replacement length clamps
        pat_bytes[0] = 8'hff;
        write_setup(5'd0, 5'd31);
        push_item(8'hff, 1'b0, 1'b0);
        push_item(8'hff, 1'b1, 1'b0);
        settle();

        // shorten the pattern while the window holds bytes
        for (int i = 0; i < 6; i++)
            pat_bytes[i] = 8'h61 + 8'(i);
        write_setup(5'd6, 5'd2);
        push_item(8'h61, 1'b0, 1'b0);
        push_item(8'h62, 1'b0, 1'b0);
        push_item(8'h63, 1'b0, 1'b0);
        push_item(8'h64, 1'b0, 1'b0);
        push_item(8'h20, 1'b0, 1'b0);
        settle();
        write_reg(ssr_pkg::CFG_PATTERN_LEN, 64'd2);
        write_reg(CFG_SPARE_6, {$urandom, $urandom});
        write_reg(CFG_SPARE_7, {$urandom, $urandom});
        release_cfg();
        push_item(8'h61, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        settle();

        while (items_pushed < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       plen_raw = 5'd0;
                1:       plen_raw = 5'd16;
                2:       plen_raw = 5'($urandom_range(17, 31));
                default: plen_raw = 5'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 9))
                0:       rlen_raw = 5'd0;
                1:       rlen_raw = 5'd16;
                2:       rlen_raw = 5'($urandom_range(17, 31));
                default: rlen_raw = 5'($urandom_range(0, 6));
            endcase
            // narrow alphabet so partial matches and overlaps are common
            base      = 8'($urandom);
            full_rand = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < WIN_DEPTH; i++) begin
                pat_bytes[i] = full_rand ? 8'($urandom) : base + 8'($urandom_range(0, 2));
                rep_bytes[i] = 8'($urandom);
            end
            settle();
            write_setup(plen_raw, rlen_raw);
            n_streams = $urandom_range(1, 3);
            // an open stream at the end of a phase is reconfigured mid-stream
            for (int s = 0; s < n_streams; s++)
                send_stream($urandom_range(1, 3 * pat_used + 4),
                            (s < n_streams - 1) || ($urandom_range(0, 3) != 0));
        end
        push_item(8'($urandom), 1'b1, 1'b0);
        settle();

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
